[src/pwfs_pkg.sv]
`default_nettype none
package pwfs_pkg;

  localparam int unsigned TB_BITS      = 10;
  localparam int unsigned ADC_BITS     = 12;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned SUM_BITS     = 23;
  localparam int unsigned NET_BITS     = 24;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASELINE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 2'd3;

  // Register reset values
  localparam logic [CFG_BITS-1:0] BASELINE_RST   = 16'd0;
  localparam logic [CFG_BITS-1:0] CUTOFF_RST     = 16'd48;
  localparam logic [TB_BITS-1:0]  CENTER_RST     = 10'd50;
  localparam logic [TB_BITS-1:0]  HALF_WIDTH_RST = 10'd5;

  typedef struct packed {
    logic [CFG_BITS-1:0] baseline;
    logic [CFG_BITS-1:0] cutoff;
    logic [TB_BITS-1:0]  center;
    logic [TB_BITS-1:0]  half_width;
  } cfg_t;

  typedef struct packed {
    logic [TB_BITS-1:0]  time_bin;
    logic [ADC_BITS-1:0] adc_value;
    logic                last_sample;
  } item_t;

  // Chosen window captured on the last sample of a record
  typedef struct packed {
    logic                good;
    logic [TB_BITS-1:0]  win_start;
    logic [TB_BITS-1:0]  win_end;
    logic [TB_BITS-1:0]  peak_time;
    logic [ADC_BITS-1:0] peak_adc;
    logic [SUM_BITS-1:0] win_sum;
  } res_t;

  typedef struct packed {
    logic                       found;
    logic [TB_BITS-1:0]         win_start;
    logic [TB_BITS-1:0]         win_end;
    logic [TB_BITS-1:0]         peak_time;
    logic [ADC_BITS-1:0]        peak_adc;
    logic signed [NET_BITS-1:0] net_sum;
  } out_t;

endpackage
`default_nettype wire

[src/pwfs_in_if.sv]
`default_nettype none
interface pwfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pwfs_pkg::TB_BITS-1:0]  time_bin;
  logic [pwfs_pkg::ADC_BITS-1:0] adc_value;
  logic                          last_sample;

  modport source (output valid, time_bin, adc_value, last_sample, input ready);
  modport sink   (input valid, time_bin, adc_value, last_sample, output ready);
endinterface
`default_nettype wire

[src/pwfs_out_if.sv]
`default_nettype none
interface pwfs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 window_found;
  logic [pwfs_pkg::TB_BITS-1:0]         window_start;
  logic [pwfs_pkg::TB_BITS-1:0]         window_end;
  logic [pwfs_pkg::TB_BITS-1:0]         peak_time;
  logic [pwfs_pkg::ADC_BITS-1:0]        peak_adc;
  logic signed [pwfs_pkg::NET_BITS-1:0] net_sum;

  modport source (output valid, window_found, window_start, window_end, peak_time,
                  peak_adc, net_sum, input ready);
  modport sink   (input valid, window_found, window_start, window_end, peak_time,
                  peak_adc, net_sum, output ready);
endinterface
`default_nettype wire

[src/pwfs_core.sv]
`default_nettype none
module pwfs_core #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire pwfs_pkg::item_t item_i,
  input  wire pwfs_pkg::cfg_t  cfg_i,
  output pwfs_pkg::res_t       res_o
);

  localparam int unsigned CNT_BITS = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TB  = pwfs_pkg::TB_BITS;
  localparam int unsigned AB  = pwfs_pkg::ADC_BITS;
  localparam int unsigned SB  = pwfs_pkg::SUM_BITS;
  localparam int unsigned CB  = pwfs_pkg::CFG_BITS;

  logic [TB-1:0]       prev_time_q, prev_time_d, older_time_q, older_time_d;
  logic [AB-1:0]       prev_adc_q, prev_adc_d, older_adc_q, older_adc_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                open_q, open_d, endv_q, endv_d, pset_q, pset_d, pnz_q, pnz_d;
  logic [TB-1:0]       start_q, start_d, end_q, end_d, lmt_q, lmt_d;
  logic [TB-1:0]       pt_q, pt_d;
  logic [AB-1:0]       pa_q, pa_d;
  logic [SB-1:0]       sum_q, sum_d, end_sum_q, end_sum_d;
  logic                ch_valid_q, ch_valid_d, ch_pnz_q, ch_pnz_d;
  logic [TB-1:0]       ch_start_q, ch_start_d, ch_pt_q, ch_pt_d;
  logic [TB:0]         ch_end_q, ch_end_d;
  logic [AB-1:0]       ch_pa_q, ch_pa_d;
  logic [SB-1:0]       ch_sum_q, ch_sum_d;

  logic [CB:0]            thr;
  logic [CB:0]            l16;
  logic signed [AB:0]     diff;
  logic signed [AB+4:0]   slope16;
  logic                   open_cond, nonneg, below_thr, do_open, close, in_range;

  // Pair terms: left sample is the held one, right sample is the new item
  assign thr       = {1'b0, cfg_i.baseline} + {1'b0, cfg_i.cutoff};
  assign l16       = (CB + 1)'({prev_adc_q, 4'b0000});
  assign diff      = $signed({1'b0, item_i.adc_value}) - $signed({1'b0, prev_adc_q});
  assign slope16   = {diff, 4'b0000};
  assign open_cond = (slope16 > $signed({1'b0, cfg_i.cutoff})) || (l16 > thr);
  assign nonneg    = item_i.adc_value >= prev_adc_q;
  assign below_thr = l16 < thr;

  // Window tracking for one pair
  always_comb begin
    prev_time_d  = item_i.time_bin;
    prev_adc_d   = item_i.adc_value;
    older_time_d = prev_time_q;
    older_adc_d  = prev_adc_q;
    cnt_d        = (cnt_q < CNT_BITS'(MAX_SAMPLES)) ? cnt_q + CNT_BITS'(1) : cnt_q;
    open_d = open_q; endv_d = endv_q; pset_d = pset_q; pnz_d = pnz_q;
    start_d = start_q; end_d = end_q; lmt_d = lmt_q; pt_d = pt_q; pa_d = pa_q;
    sum_d = sum_q; end_sum_d = end_sum_q;
    ch_valid_d = ch_valid_q; ch_pnz_d = ch_pnz_q; ch_start_d = ch_start_q;
    ch_end_d = ch_end_q; ch_pt_d = ch_pt_q; ch_pa_d = ch_pa_q; ch_sum_d = ch_sum_q;
    do_open  = 1'b0;
    close    = 1'b0;
    in_range = 1'b0;
    if (cnt_q != '0) begin
      if (!open_q) begin
        do_open = open_cond;
      end else begin
        sum_d = sum_q + SB'(prev_adc_q);
        if (nonneg) begin
          lmt_d = prev_time_q;
        end else begin
          end_d     = prev_time_q;
          endv_d    = 1'b1;
          end_sum_d = sum_d;
          if (!pset_q) begin
            pset_d = 1'b1;
            pnz_d  = cnt_q >= CNT_BITS'(3);
            pt_d   = older_time_q;
            pa_d   = older_adc_q;
          end
        end
        close    = (endv_d && (lmt_d > end_d)) || below_thr;
        in_range = (({1'b0, pt_d} + {1'b0, cfg_i.half_width}) >= {1'b0, cfg_i.center}) &&
                   ({1'b0, pt_d} <= ({1'b0, cfg_i.center} + {1'b0, cfg_i.half_width}));
        if (close) begin
          if (pset_d && in_range) begin
            ch_valid_d = 1'b1;
            ch_start_d = start_d;
            ch_end_d   = endv_d ? {1'b0, end_d} : {1'b1, {TB{1'b0}}};
            ch_pt_d    = pt_d;
            ch_pa_d    = pa_d;
            ch_pnz_d   = pnz_d;
            ch_sum_d   = end_sum_d;
          end
          open_d  = 1'b0;
          endv_d  = 1'b0;
          pset_d  = 1'b0;
          do_open = open_cond;
        end
      end
      if (do_open) begin
        open_d    = 1'b1;
        start_d   = prev_time_q;
        lmt_d     = prev_time_q;
        endv_d    = 1'b0;
        end_d     = '0;
        pset_d    = 1'b0;
        pnz_d     = 1'b0;
        pt_d      = '0;
        pa_d      = '0;
        sum_d     = SB'(prev_adc_q);
        end_sum_d = '0;
      end
    end
  end

  // Result of the record, taken from the chosen window after this pair
  always_comb begin
    res_o.good      = ch_valid_d && (cfg_i.center != '0) && ch_pnz_d && !ch_end_d[TB] &&
                      (ch_start_d < ch_end_d[TB-1:0]);
    res_o.win_start = ch_start_d;
    res_o.win_end   = ch_end_d[TB-1:0];
    res_o.peak_time = ch_pt_d;
    res_o.peak_adc  = ch_pa_d;
    res_o.win_sum   = ch_sum_d;
  end

  // Advance the state; clear the record after its last sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0; prev_adc_q <= '0; older_time_q <= '0; older_adc_q <= '0;
      cnt_q <= '0; open_q <= 1'b0; endv_q <= 1'b0; pset_q <= 1'b0; pnz_q <= 1'b0;
      start_q <= '0; end_q <= '0; lmt_q <= '0; pt_q <= '0; pa_q <= '0;
      sum_q <= '0; end_sum_q <= '0;
      ch_valid_q <= 1'b0; ch_pnz_q <= 1'b0; ch_start_q <= '0; ch_end_q <= '0;
      ch_pt_q <= '0; ch_pa_q <= '0; ch_sum_q <= '0;
    end else if (step_i) begin
      if (item_i.last_sample) begin
        prev_time_q <= '0; prev_adc_q <= '0; older_time_q <= '0; older_adc_q <= '0;
        cnt_q <= '0; open_q <= 1'b0; endv_q <= 1'b0; pset_q <= 1'b0; pnz_q <= 1'b0;
        start_q <= '0; end_q <= '0; lmt_q <= '0; pt_q <= '0; pa_q <= '0;
        sum_q <= '0; end_sum_q <= '0;
        ch_valid_q <= 1'b0; ch_pnz_q <= 1'b0; ch_start_q <= '0; ch_end_q <= '0;
        ch_pt_q <= '0; ch_pa_q <= '0; ch_sum_q <= '0;
      end else begin
        prev_time_q <= prev_time_d; prev_adc_q <= prev_adc_d;
        older_time_q <= older_time_d; older_adc_q <= older_adc_d;
        cnt_q <= cnt_d; open_q <= open_d; endv_q <= endv_d; pset_q <= pset_d;
        pnz_q <= pnz_d; start_q <= start_d; end_q <= end_d; lmt_q <= lmt_d;
        pt_q <= pt_d; pa_q <= pa_d; sum_q <= sum_d; end_sum_q <= end_sum_d;
        ch_valid_q <= ch_valid_d; ch_pnz_q <= ch_pnz_d; ch_start_q <= ch_start_d;
        ch_end_q <= ch_end_d; ch_pt_q <= ch_pt_d; ch_pa_q <= ch_pa_d;
        ch_sum_q <= ch_sum_d;
      end
    end
  end

endmodule
`default_nettype wire

[src/pwfs_sum.sv]
`default_nettype none
module pwfs_sum (
  input  wire pwfs_pkg::res_t                res_i,
  input  wire logic [pwfs_pkg::CFG_BITS-1:0] baseline_i,
  output pwfs_pkg::out_t                     out_o
);

  localparam int unsigned TB = pwfs_pkg::TB_BITS;
  localparam int unsigned SB = pwfs_pkg::SUM_BITS;
  localparam int unsigned CB = pwfs_pkg::CFG_BITS;
  localparam int unsigned PB = CB + TB + 1;
  localparam int unsigned NB = SB + 5;

  logic [TB:0]          width;
  logic [PB-1:0]        pedestal;
  logic signed [NB-1:0] num;
  logic signed [NB-1:0] num_adj;
  logic signed [NB-1:0] quot;

  // Window width times pedestal, taken off the sum scaled by 16
  assign width    = {1'b0, res_i.win_end} - {1'b0, res_i.win_start} + (TB + 1)'(1);
  assign pedestal = PB'(baseline_i) * PB'(width);
  assign num      = $signed({1'b0, res_i.win_sum, 4'b0000}) - $signed(NB'(pedestal));
  // Bias negatives so the shift truncates toward zero
  assign num_adj  = num[NB-1] ? num + NB'(15) : num;
  assign quot     = num_adj >>> 4;

  // Zero every field of an invalid result
  always_comb begin
    out_o = '0;
    if (res_i.good) begin
      out_o.found     = 1'b1;
      out_o.win_start = res_i.win_start;
      out_o.win_end   = res_i.win_end;
      out_o.peak_time = res_i.peak_time;
      out_o.peak_adc  = res_i.peak_adc;
      out_o.net_sum   = quot[pwfs_pkg::NET_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

[src/pulse_window_finder_sum.sv]
// A result item passes from the input register through the result register (window
// update) into the output register (net sum); a last sample may wait on the output side.
// Throughput: one sample a cycle while no last sample waits; the window state is updated for each step.
// Samples that are not last in a record never wait on the output side.
// Reset: asynchronous, active low; clears all record state and loads register defaults.
`default_nettype none
module pulse_window_finder_sum #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pwfs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [pwfs_pkg::CFG_BITS-1:0]       cfg_data_i,
  pwfs_in_if.sink                                  in_i,
  pwfs_out_if.source                               out_o
);

  pwfs_pkg::cfg_t  cfg_q;
  pwfs_pkg::item_t s1_item_q;
  pwfs_pkg::res_t  s2_res_q, core_res;
  pwfs_pkg::out_t  out_q, sum_out;
  logic            s1_valid_q, s2_valid_q, out_valid_q;
  logic            out_free, s2_free, s1_step, in_ready;

  // Stage handshakes: an item moves when the stage ahead is empty or moving; a sample that is not last steps freely
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_step  = s1_valid_q && (!s1_item_q.last_sample || s2_free);
  assign in_ready = !s1_valid_q || s1_step;
  assign in_i.ready = in_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline   <= pwfs_pkg::BASELINE_RST;
      cfg_q.cutoff     <= pwfs_pkg::CUTOFF_RST;
      cfg_q.center     <= pwfs_pkg::CENTER_RST;
      cfg_q.half_width <= pwfs_pkg::HALF_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwfs_pkg::CFG_BASELINE:   cfg_q.baseline   <= cfg_data_i;
        pwfs_pkg::CFG_CUTOFF:     cfg_q.cutoff     <= cfg_data_i;
        pwfs_pkg::CFG_CENTER:     cfg_q.center     <= cfg_data_i[pwfs_pkg::TB_BITS-1:0];
        pwfs_pkg::CFG_HALF_WIDTH: cfg_q.half_width <= cfg_data_i[pwfs_pkg::TB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q.time_bin    <= in_i.time_bin;
      s1_item_q.adc_value   <= in_i.adc_value;
      s1_item_q.last_sample <= in_i.last_sample;
    end
  end

  pwfs_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_step),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  // Hold the record result until the sum stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_step && s1_item_q.last_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_step && s1_item_q.last_sample) begin
      s2_res_q <= core_res;
    end
  end

  pwfs_sum u_sum (
    .res_i      (s2_res_q),
    .baseline_i (cfg_q.baseline),
    .out_o      (sum_out)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      out_q <= sum_out;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_found = out_q.found;
  assign out_o.window_start = out_q.win_start;
  assign out_o.window_end   = out_q.win_end;
  assign out_o.peak_time    = out_q.peak_time;
  assign out_o.peak_adc     = out_q.peak_adc;
  assign out_o.net_sum      = out_q.net_sum;

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.win_start == '0 && out_q.win_end == '0 &&
      out_q.peak_time == '0 && out_q.peak_adc == '0 && out_q.net_sum == '0))
    else $error("empty result carries non-zero fields");

  a_found_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.found) |-> (out_q.win_start < out_q.win_end))
    else $error("found window with start not before end");

  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_step && s1_item_q.last_sample) |=> s2_valid_q)
    else $error("last sample result lost before sum stage");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 85;
  localparam int PHASES      = 8;
  localparam int SAMPLE_CAP  = 1024;
  localparam int DRAIN_WAIT  = 8;
  localparam pwfs_pkg::out_t NO_WINDOW = '0;

  // One row of the directed walk: the sample, and a typed expectation where flagged
  typedef struct packed {
    pwfs_pkg::item_t smp;
    logic            typed;
    pwfs_pkg::out_t  want;
  } dir_row_t;

  localparam int DIR_N = 27;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // single-sample record: no pair, so nothing to find
    {10'd0,    12'd4095, 1'b1, 1'b1, NO_WINDOW},
    // flat zero record across the time bin extremes
    {10'd1023, 12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd0,    12'd0,    1'b1, 1'b1, NO_WINDOW},
    // level opens a window that closes before any falling pair: no peak
    {10'd48,   12'd100,  1'b0, 1'b0, NO_WINDOW},
    {10'd49,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd50,   12'd0,    1'b1, 1'b1, NO_WINDOW},
    // peak lands on the first sample of the record
    {10'd50,   12'd200,  1'b0, 1'b0, NO_WINDOW},
    {10'd51,   12'd300,  1'b0, 1'b0, NO_WINDOW},
    {10'd52,   12'd100,  1'b0, 1'b0, NO_WINDOW},
    {10'd53,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd54,   12'd0,    1'b1, 1'b1, NO_WINDOW},
    // clean pulse inside the search range
    {10'd46,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd47,   12'd1500, 1'b0, 1'b0, NO_WINDOW},
    {10'd48,   12'd4095, 1'b0, 1'b0, NO_WINDOW},
    {10'd49,   12'd3000, 1'b0, 1'b0, NO_WINDOW},
    {10'd50,   12'd1000, 1'b0, 1'b0, NO_WINDOW},
    {10'd51,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd52,   12'd0,    1'b1, 1'b0, NO_WINDOW},
    // window still open when the record ends
    {10'd10,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd11,   12'd500,  1'b0, 1'b0, NO_WINDOW},
    {10'd12,   12'd600,  1'b1, 1'b1, NO_WINDOW},
    // time bins out of order
    {10'd55,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd53,   12'd2000, 1'b0, 1'b0, NO_WINDOW},
    {10'd53,   12'd4095, 1'b0, 1'b0, NO_WINDOW},
    {10'd50,   12'd800,  1'b0, 1'b0, NO_WINDOW},
    {10'd52,   12'd0,    1'b0, 1'b0, NO_WINDOW},
    {10'd40,   12'd0,    1'b1, 1'b0, NO_WINDOW}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [pwfs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [pwfs_pkg::CFG_BITS-1:0]     cfg_data_i;

  pwfs_in_if  in_if ();
  pwfs_out_if out_if ();

  pulse_window_finder_sum dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Register copy
  int unsigned base_lvl, cutoff, ctr, half_w;

  // Sample history and the window being built
  logic [pwfs_pkg::TB_BITS-1:0]  last_tb, earlier_tb;
  logic [pwfs_pkg::ADC_BITS-1:0] last_adc, earlier_adc;
  int unsigned                   n_samples;
  bit                            open_w, end_ok, peak_seen, peak_late;
  logic [pwfs_pkg::TB_BITS-1:0]  open_start, open_end, crest_tb, peak_tb;
  logic [pwfs_pkg::ADC_BITS-1:0] peak_adc;
  logic [pwfs_pkg::SUM_BITS-1:0] acc_sum, acc_at_end;

  // Window kept for the record result
  bit                            pick_ok, pick_late;
  logic [pwfs_pkg::TB_BITS-1:0]  pick_start, pick_peak_tb;
  logic [pwfs_pkg::TB_BITS:0]    pick_end;
  logic [pwfs_pkg::ADC_BITS-1:0] pick_peak_adc;
  logic [pwfs_pkg::SUM_BITS-1:0] pick_sum;

  pwfs_pkg::out_t due_windows [$];
  int   mismatches  = 0;
  int   cycle_count = 0;
  int   gap_pct     = 0;
  int   stall_pct   = 0;

  task automatic clear_record();
    last_tb = '0; last_adc = '0; earlier_tb = '0; earlier_adc = '0; n_samples = 0;
    open_w = 0; end_ok = 0; peak_seen = 0; peak_late = 0;
    open_start = '0; open_end = '0; crest_tb = '0; peak_tb = '0; peak_adc = '0;
    acc_sum = '0; acc_at_end = '0;
    pick_ok = 0; pick_late = 0; pick_start = '0; pick_end = '0;
    pick_peak_tb = '0; pick_peak_adc = '0; pick_sum = '0;
  endtask

  // Open a window at the left sample of the pair on a steep rise or a high level
  task automatic maybe_open(input logic [pwfs_pkg::TB_BITS-1:0] lt,
                            input logic [pwfs_pkg::ADC_BITS-1:0] la,
                            input int slope, input int unsigned l16, input int unsigned thr);
    if (slope > int'(cutoff) || l16 > thr) begin
      open_w = 1; open_start = lt; crest_tb = lt;
      end_ok = 0; open_end = '0;
      peak_seen = 0; peak_late = 0; peak_tb = '0; peak_adc = '0;
      acc_sum = {11'd0, la}; acc_at_end = '0;
    end
  endtask

  task automatic pair_step(input logic [pwfs_pkg::TB_BITS-1:0] lt,
                           input logic [pwfs_pkg::ADC_BITS-1:0] la,
                           input logic [pwfs_pkg::ADC_BITS-1:0] ra);
    int unsigned thr, l16;
    int slope, lo, hi, pt;
    thr = base_lvl + cutoff;
    l16 = int'(la) * 16;
    slope = (int'(ra) - int'(la)) * 16;
    if (!open_w) begin
      maybe_open(lt, la, slope, l16, thr);
    end else begin
      acc_sum = acc_sum + {11'd0, la};
      // rising or flat pairs advance the crest, falling ones the end
      if (slope >= 0) begin
        crest_tb = lt;
      end else begin
        open_end = lt;
        end_ok = 1;
        acc_at_end = acc_sum;
        if (!peak_seen) begin
          peak_seen = 1;
          peak_late = (n_samples >= 3);
          peak_tb = earlier_tb;
          peak_adc = earlier_adc;
        end
      end
      // close, keep it if the peak sits in the search range, then try to reopen
      if ((end_ok && crest_tb > open_end) || l16 < thr) begin
        lo = int'(ctr) - int'(half_w);
        hi = int'(ctr) + int'(half_w);
        pt = int'(peak_tb);
        if (peak_seen && lo <= pt && pt <= hi) begin
          pick_ok = 1;
          pick_start = open_start;
          pick_end = end_ok ? {1'b0, open_end} : 11'h400;
          pick_peak_tb = peak_tb;
          pick_peak_adc = peak_adc;
          pick_late = peak_late;
          pick_sum = acc_at_end;
        end
        open_w = 0; end_ok = 0; peak_seen = 0;
        maybe_open(lt, la, slope, l16, thr);
      end
    end
  endtask

  function automatic pwfs_pkg::out_t record_result();
    pwfs_pkg::out_t r;
    longint span, num, q;
    r = NO_WINDOW;
    if (pick_ok && ctr > 0 && pick_late && pick_end <= 11'd1023 &&
        {1'b0, pick_start} < pick_end) begin
      span = longint'(pick_end) - longint'(pick_start) + 1;
      num = longint'(pick_sum) * 16 - longint'(base_lvl) * span;
      q = (num >= 0) ? num / 16 : -((-num) / 16);
      r.found = 1'b1;
      r.win_start = pick_start;
      r.win_end = pick_end[pwfs_pkg::TB_BITS-1:0];
      r.peak_time = pick_peak_tb;
      r.peak_adc = pick_peak_adc;
      r.net_sum = q[pwfs_pkg::NET_BITS-1:0];
    end
    return r;
  endfunction

  task automatic track_sample(input pwfs_pkg::item_t smp, output pwfs_pkg::out_t res,
                              output bit has);
    res = NO_WINDOW;
    has = 0;
    if (n_samples > 0) pair_step(last_tb, last_adc, smp.adc_value);
    earlier_tb = last_tb;
    earlier_adc = last_adc;
    last_tb = smp.time_bin;
    last_adc = smp.adc_value;
    if (n_samples < SAMPLE_CAP) n_samples++;
    if (smp.last_sample) begin
      res = record_result();
      has = 1;
      clear_record();
    end
  endtask

  // Offer one sample, hold it until accepted, then predict
  task automatic send_sample(input pwfs_pkg::item_t smp, input logic typed,
                             input pwfs_pkg::out_t want);
    pwfs_pkg::out_t got;
    bit             has;
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.time_bin    <= smp.time_bin;
    in_if.adc_value   <= smp.adc_value;
    in_if.last_sample <= smp.last_sample;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    track_sample(smp, got, has);
    if (has) due_windows.insert(due_windows.size(), typed ? want : got);
  endtask

  // Hold the sender until every result is back, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [pwfs_pkg::CFG_IDX_BITS-1:0] idx,
                         input logic [pwfs_pkg::CFG_BITS-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [pwfs_pkg::CFG_BITS-1:0] b,
                           input logic [pwfs_pkg::CFG_BITS-1:0] c,
                           input logic [pwfs_pkg::TB_BITS-1:0] ct,
                           input logic [pwfs_pkg::TB_BITS-1:0] hw);
    put_reg(pwfs_pkg::CFG_BASELINE, b);
    put_reg(pwfs_pkg::CFG_CUTOFF, c);
    put_reg(pwfs_pkg::CFG_CENTER, {6'd0, ct});
    put_reg(pwfs_pkg::CFG_HALF_WIDTH, {6'd0, hw});
    cfg_we_i <= 1'b0;
    base_lvl = b;
    cutoff = c;
    ctr = ct;
    half_w = hw;
  endtask

  // Triangle pulse: d is the distance from the pulse top
  function automatic int pulse_shape(input int d, input int amp, input int rise, input int fall);
    if (d <= 0 && -d < rise) return amp * (rise + d) / rise;
    if (d > 0 && d < fall) return amp * (fall - d) / fall;
    return 0;
  endfunction

  // Build a record around the search centre: pedestal, noise and one or two pulses, or random values when scrambled
  task automatic play_record(input int len);
    pwfs_pkg::item_t smp;
    int    t0, ped, pk, amp, rise, fall, pk2, amp2, v;
    bit    scramble, twin;
    scramble = ($urandom_range(7) == 0);
    twin = ($urandom_range(2) == 0);
    ped = base_lvl / 16;
    if (ped > 4095) ped = 4095;
    t0 = int'(ctr) - int'($urandom_range(0, len - 1));
    if (t0 > SAMPLE_CAP - len) t0 = SAMPLE_CAP - len;
    if (t0 < 0) t0 = 0;
    pk = int'(ctr) - t0 + int'($urandom_range(0, 4)) - 1;
    if ($urandom_range(3) == 0 || pk < 0 || pk >= len) pk = $urandom_range(0, len - 1);
    pk2 = $urandom_range(0, len - 1);
    amp = $urandom_range(0, 4095);
    amp2 = $urandom_range(0, 4095);
    rise = $urandom_range(1, 6);
    fall = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      v = ped + int'($urandom_range(0, 4)) - 2 + pulse_shape(i - pk, amp, rise, fall);
      if (twin) v += pulse_shape(i - pk2, amp2, rise, fall);
      if (scramble) v = $urandom_range(0, 4095);
      if (v > 4095) v = 4095;
      if (v < 0) v = 0;
      smp.time_bin = scramble ? pwfs_pkg::TB_BITS'($urandom_range(0, 1023)) :
                                pwfs_pkg::TB_BITS'(t0 + i);
      smp.adc_value = pwfs_pkg::ADC_BITS'(v);
      smp.last_sample = (i == len - 1);
      send_sample(smp, 1'b0, NO_WINDOW);
    end
  endtask

  task automatic check_field(input string what, input logic [pwfs_pkg::NET_BITS-1:0] want,
                             input logic [pwfs_pkg::NET_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Drive ready and check each result item against the oldest expectation
  always @(posedge clk_i) begin
    pwfs_pkg::out_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
      if (out_if.valid && out_if.ready) begin
        if (due_windows.size() == 0) begin
          $display("%0t: result item with no window pending, got found=%0b start=%0d",
                   $time, out_if.window_found, out_if.window_start);
          mismatches++;
        end else begin
          want = due_windows.pop_front();
          check_field("window_found", pwfs_pkg::NET_BITS'(want.found),
                      pwfs_pkg::NET_BITS'(out_if.window_found));
          check_field("window_start", pwfs_pkg::NET_BITS'(want.win_start),
                      pwfs_pkg::NET_BITS'(out_if.window_start));
          check_field("window_end", pwfs_pkg::NET_BITS'(want.win_end),
                      pwfs_pkg::NET_BITS'(out_if.window_end));
          check_field("peak_time", pwfs_pkg::NET_BITS'(want.peak_time),
                      pwfs_pkg::NET_BITS'(out_if.peak_time));
          check_field("peak_adc", pwfs_pkg::NET_BITS'(want.peak_adc),
                      pwfs_pkg::NET_BITS'(out_if.peak_adc));
          check_field("net_sum", want.net_sum, out_if.net_sum);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int n, len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pwfs_pkg::CFG_BASELINE;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.time_bin = '0;
    in_if.adc_value = '0;
    in_if.last_sample = 1'b0;
    out_if.ready = 1'b0;
    base_lvl = pwfs_pkg::BASELINE_RST;
    cutoff = pwfs_pkg::CUTOFF_RST;
    ctr = pwfs_pkg::CENTER_RST;
    half_w = pwfs_pkg::HALF_WIDTH_RST;
    clear_record();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed records at the register defaults
    for (int k = 0; k < DIR_N; k++) begin
      send_sample(DIR_ROWS[k].smp, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    // Random records, one register setting and one pacing mode per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: write_cfg(16'd0, 16'd0, 10'd1023, 10'd0);
          2: write_cfg(16'hFFFF, 16'hFFFF, 10'd0, 10'd1023);
          3: write_cfg(16'd800, 16'd16, 10'd300, 10'd20);
          4: write_cfg(16'd1600, 16'd32, 10'd512, 10'd1023);
          5: write_cfg(16'd0, 16'd48, 10'd1, 10'd3);
          default: write_cfg(pwfs_pkg::CFG_BITS'($urandom_range(0, 8000)),
                             pwfs_pkg::CFG_BITS'($urandom_range(0, 200)),
                             pwfs_pkg::TB_BITS'($urandom_range(1, 1023)),
                             pwfs_pkg::TB_BITS'($urandom_range(0, 30)));
        endcase
      end
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        // one record long enough to saturate the sample count
        if (ph == 5 && n == 0) len = 1100;
        else if ($urandom_range(9) == 0) len = $urandom_range(1, 2);
        else len = $urandom_range(4, 24);
        play_record(len);
        n += len;
        if ($urandom_range(15) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
